[hdl/cmfu_pkg.sv]
// ----------------------------------------------------------------------------
// cmfu_pkg: shared types and constants for the motor feedback unwrapper
// Stream item layouts, per-slot record and encoder constants.
// ----------------------------------------------------------------------------
`default_nettype none

package cmfu_pkg;

    localparam int ANGLE_W   = 13;
    localparam int TIME_W    = 32;
    localparam int TIMEOUT_W = 16;
    localparam int BASE_W    = 11;

    localparam logic [6:0]  FRAME_LEN      = 7'd8;
    localparam logic [13:0] HALF_TURN      = 14'sd4096;
    localparam logic [13:0] FULL_TURN      = 14'd8192;

    // register offsets (decoded on paddr[2])
    localparam logic REG_BASE_ID = 1'b0;
    localparam logic REG_TIMEOUT = 1'b1;

    localparam logic [10:0] BASE_ID_RESET = 11'd513;
    localparam logic [15:0] TIMEOUT_RESET = 16'd100;

    // input item, last field in the lowest bits
    typedef struct packed {
        logic [2:0]  pad;
        logic [63:0] payload;
        logic [6:0]  data_length;
        logic        is_classic;
        logic        is_data_frame;
        logic        is_standard_id;
        logic [10:0] frame_id;
        logic [31:0] now_ms;
    } in_item_t;

    // result item, last field in the lowest bits
    typedef struct packed {
        logic               all_online;
        logic [31:0]        slot_frames;
        logic [7:0]         temperature;
        logic signed [15:0] phase_current;
        logic signed [15:0] motor_speed;
        logic signed [31:0] turn_position;
        logic [12:0]        encoder_angle;
        logic [1:0]         motor_index;
    } out_item_t;

    // per-slot memory record
    typedef struct packed {
        logic [ANGLE_W-1:0] last_angle;
        logic [31:0]        turn_total;
        logic [31:0]        frame_count;
    } slot_rec_t;

    // slot being updated by the item in the update stage
    typedef struct packed {
        logic        en;
        logic [3:0]  slot;
    } slot_upd_t;

endpackage

`default_nettype wire

[hdl/cmfu_online_check.sv]
// ----------------------------------------------------------------------------
// cmfu_online_check: all-motors-online evaluation
// Parallel per-slot timeout compare, with the current update folded in.
// ----------------------------------------------------------------------------
`default_nettype none

module cmfu_online_check
    import cmfu_pkg::*;
#(
    parameter int MOTOR_COUNT = 4
)
(
    input  wire logic [MOTOR_COUNT-1:0]             seen,
    input  wire logic [MOTOR_COUNT-1:0][TIME_W-1:0] rx_time,
    input  wire slot_upd_t                          upd,
    input  wire logic [TIME_W-1:0]                  now_ms,
    input  wire logic [TIMEOUT_W-1:0]               timeout_ms,
    output logic                                    all_online
);

    logic [MOTOR_COUNT-1:0] slot_ok;

    always_comb
    begin
        for (int i = 0; i < MOTOR_COUNT; i++)
        begin
            logic              hit;
            logic [TIME_W-1:0] age;
            hit = upd.en && (upd.slot == 4'(i));
            age = hit ? '0 : (now_ms - rx_time[i]);
            slot_ok[i] = (seen[i] || hit) && (age < {16'd0, timeout_ms});
        end
    end

    assign all_online = &slot_ok;

endmodule

`default_nettype wire

[hdl/can_motor_feedback_unwrapper_unit.sv]
// ----------------------------------------------------------------------------
// can_motor_feedback_unwrapper_unit: multi-turn motor feedback decoder
// Checks CAN feedback frames, unwraps the encoder angle per motor slot and
// reports speed, current, temperature and the all-motors-online status.
// ----------------------------------------------------------------------------
// Usage:
//   s_* carries one CAN frame or an online query per transfer (tuser = query).
//   m_* returns exactly one result per input transfer, in order; m_tuser is
//   set when the frame was accepted and updated a motor slot.
//   APB registers: 0x0 feedback base id, 0x4 offline timeout in ms. Write
//   them only while no transfer is in flight.
// Pipeline: slot memory read as the transfer enters the update stage, then
//   unwrap/accumulate and write back into the output register.
// Throughput: one transfer per cycle while the output is not stalled. The slot memory is read when an item
//   enters and written as it leaves the update stage; a back-to-back item
//   on the same slot takes the forwarded write-back record.
// Reset: all slots unseen, counts and totals read as zero, registers at
//   their defaults; no clearing pass, input is taken right after reset.
// Stall: a held m_tready keeps the result; one more item is taken into the
//   update stage, after which s_tready drops until the output is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module can_motor_feedback_unwrapper_unit
    import cmfu_pkg::*;
#(
    parameter int MOTOR_COUNT = 4
)
(
    input  wire logic         clk,
    input  wire logic         rst_n,

    input  wire logic         s_tvalid,
    output logic              s_tready,
    // now_ms[31:0], frame_id[42:32], is_standard_id[43], is_data_frame[44],
    // is_classic[45], data_length[52:46], payload[116:53], zero pad
    input  wire logic [119:0] s_tdata,
    // req_type[0]
    input  wire logic         s_tuser,

    output logic              m_tvalid,
    input  wire logic         m_tready,
    // motor_index[1:0], encoder_angle[14:2], turn_position[46:15],
    // motor_speed[62:47], phase_current[78:63], temperature[86:79],
    // slot_frames[118:87], all_online[119]
    output logic [119:0]      m_tdata,
    // accepted[0]
    output logic              m_tuser,

    input  wire logic         psel,
    input  wire logic         penable,
    input  wire logic         pwrite,
    input  wire logic [2:0]   paddr,
    input  wire logic [31:0]  pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);

    localparam int SLOT_W = (MOTOR_COUNT > 1) ? $clog2(MOTOR_COUNT) : 1;

    // configuration
    logic [BASE_W-1:0]    base_id_reg;
    logic [TIMEOUT_W-1:0] timeout_reg;
    logic                 cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_comb
    begin
        unique case (paddr[2])
            REG_BASE_ID: prdata = {21'd0, base_id_reg};
            REG_TIMEOUT: prdata = {16'd0, timeout_reg};
            default:     prdata = '0;
        endcase
    end

    // input decode
    in_item_t          in_item;
    logic [BASE_W:0]   id_diff;
    logic              in_win;
    logic              in_acc;
    logic [SLOT_W-1:0] in_slot;

    assign in_item = s_tdata;
    assign id_diff = {1'b0, in_item.frame_id} - {1'b0, base_id_reg};
    assign in_win  = !id_diff[BASE_W] && (id_diff[BASE_W-1:0] < BASE_W'(MOTOR_COUNT));
    assign in_acc  = !s_tuser && in_item.is_standard_id && in_item.is_data_frame
                  && in_item.is_classic && (in_item.data_length == FRAME_LEN)
                  && in_win && (in_item.payload[63:61] == 3'd0);
    assign in_slot = in_win ? id_diff[SLOT_W-1:0] : '0;

    // pipeline control
    logic p1_valid_reg;
    logic out_valid_reg;
    logic out_adv;
    logic p1_load;
    logic wr_en;

    assign out_adv  = !out_valid_reg || m_tready;
    assign s_tready = !p1_valid_reg || out_adv;
    assign p1_load  = s_tvalid && s_tready;

    // update stage payload
    logic               p1_acc_reg;
    logic [SLOT_W-1:0]  p1_slot_reg;
    logic [ANGLE_W-1:0] p1_angle_reg;
    logic [TIME_W-1:0]  p1_now_reg;
    logic [39:0]        p1_meas_reg;

    // slot state
    slot_rec_t                         slot_mem [MOTOR_COUNT];
    slot_rec_t                         rd_rec_reg;
    slot_rec_t                         wb_rec_reg;
    logic [SLOT_W-1:0]                 wb_slot_reg;
    logic [MOTOR_COUNT-1:0]            seen_reg;
    logic [MOTOR_COUNT-1:0][TIME_W-1:0] rx_time_reg;

    // unwrap and accumulate
    slot_rec_t          cur_rec;
    slot_rec_t          rec_next;
    logic               prev_seen;
    logic signed [13:0] step_raw;
    logic signed [13:0] step;
    logic               online;
    slot_upd_t          upd;
    out_item_t          res_next;

    assign wr_en = p1_valid_reg && p1_acc_reg && out_adv;

    always_comb
    begin
        cur_rec   = (wb_slot_reg == p1_slot_reg) ? wb_rec_reg : rd_rec_reg;
        prev_seen = seen_reg[p1_slot_reg];
        step_raw  = $signed({1'b0, p1_angle_reg}) - $signed({1'b0, cur_rec.last_angle});
        priority if (step_raw > $signed(HALF_TURN))
            step = step_raw - $signed(FULL_TURN);
        else if (step_raw < -$signed(HALF_TURN))
            step = step_raw + $signed(FULL_TURN);
        else
            step = step_raw;

        rec_next.last_angle  = p1_angle_reg;
        rec_next.turn_total  = prev_seen ? cur_rec.turn_total + 32'(step) : '0;
        rec_next.frame_count = prev_seen ? cur_rec.frame_count + 32'd1 : 32'd1;
    end

    assign upd.en   = p1_acc_reg;
    assign upd.slot = 4'({3'd0, p1_slot_reg});

    cmfu_online_check #(
        .MOTOR_COUNT (MOTOR_COUNT)
    ) u_online (
        .seen       (seen_reg),
        .rx_time    (rx_time_reg),
        .upd        (upd),
        .now_ms     (p1_now_reg),
        .timeout_ms (timeout_reg),
        .all_online (online)
    );

    logic [SLOT_W+1:0] slot_ext;
    assign slot_ext = {2'b00, p1_slot_reg};

    always_comb
    begin
        res_next = '0;
        if (p1_acc_reg)
        begin
            res_next.motor_index   = slot_ext[1:0];
            res_next.encoder_angle = p1_angle_reg;
            res_next.turn_position = rec_next.turn_total;
            res_next.motor_speed   = p1_meas_reg[39:24];
            res_next.phase_current = p1_meas_reg[23:8];
            res_next.temperature   = p1_meas_reg[7:0];
            res_next.slot_frames   = rec_next.frame_count;
        end
        res_next.all_online = online;
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_id_reg   <= BASE_ID_RESET;
            timeout_reg   <= TIMEOUT_RESET;
            p1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            seen_reg      <= '0;
            rx_time_reg   <= '0;
            wb_slot_reg   <= '0;
        end
        else
        begin
            if (cfg_wr)
            begin
                unique case (paddr[2])
                    REG_BASE_ID: base_id_reg <= pwdata[BASE_W-1:0];
                    REG_TIMEOUT: timeout_reg <= pwdata[TIMEOUT_W-1:0];
                    default: ;
                endcase
            end
            if (out_adv)
                out_valid_reg <= p1_valid_reg;
            if (s_tready)
                p1_valid_reg <= s_tvalid;
            if (wr_en)
            begin
                seen_reg[p1_slot_reg]    <= 1'b1;
                rx_time_reg[p1_slot_reg] <= p1_now_reg;
                wb_slot_reg              <= p1_slot_reg;
            end
        end
    end

    // payload and slot memory
    out_item_t out_item_reg;
    logic      out_acc_reg;

    always_ff @(posedge clk)
    begin
        if (p1_load)
        begin
            p1_acc_reg   <= in_acc;
            p1_slot_reg  <= in_slot;
            p1_angle_reg <= in_item.payload[60:48];
            p1_now_reg   <= in_item.now_ms;
            p1_meas_reg  <= in_item.payload[47:8];
            rd_rec_reg   <= slot_mem[in_slot];
        end
        if (wr_en)
        begin
            slot_mem[p1_slot_reg] <= rec_next;
            wb_rec_reg            <= rec_next;
        end
        if (out_adv && p1_valid_reg)
        begin
            out_item_reg <= res_next;
            out_acc_reg  <= p1_acc_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_item_reg;
    assign m_tuser  = out_acc_reg;

endmodule

`default_nettype wire
